>>> src/gtcs_pkg.sv
// Package with the shared types and constants of the callback slot table.
package gtcs_pkg;

    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
    localparam int MOD_STEPS = 2;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FIRE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_CLOSE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [7:0]  handle_slot;
        logic [7:0]  handle_gen;
        logic [31:0] new_payload;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  out_slot;
        logic [7:0]  out_gen;
        logic        evicted;
        logic [31:0] out_payload;
    } res_t;

    typedef struct packed {
        logic rd;
        logic wr_alloc;
        logic clr_one;
        logic clr_all;
    } store_ctl_t;

endpackage

>>> src/gtcs_slot_store.sv
// Slot storage: valid flops, generation and payload memories, free-slot search.
module gtcs_slot_store #(
    parameter int SLOTS     = 8,
    parameter int PAYLOAD_W = 32,
    parameter int IW        = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gtcs_pkg::store_ctl_t   ctl,
    input  logic [IW-1:0]          idx,
    input  logic [7:0]             wr_gen,
    input  logic [PAYLOAD_W-1:0]   wr_pay,
    output logic [SLOTS-1:0]       valid_vec,
    output logic                   free_any,
    output logic [IW-1:0]          free_idx,
    output logic [7:0]             gen_q,
    output logic [PAYLOAD_W-1:0]   pay_q
);
    import gtcs_pkg::*;

    logic [7:0]           gen_mem [SLOTS];
    logic [PAYLOAD_W-1:0] pay_mem [SLOTS];
    logic [SLOTS-1:0]     valid_reg;
    logic [SLOTS-1:0]     written_reg;
    logic [7:0]           gen_rd_reg;
    logic                 seen_reg;
    logic [PAYLOAD_W-1:0] pay_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            written_reg <= '0;
        end
        else if (ctl.clr_all)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_alloc)
        begin
            valid_reg[idx]   <= 1'b1;
            written_reg[idx] <= 1'b1;
        end
        else if (ctl.clr_one)
        begin
            valid_reg[idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_alloc)
        begin
            gen_mem[idx] <= wr_gen;
            pay_mem[idx] <= wr_pay;
        end
        if (ctl.rd)
        begin
            gen_rd_reg <= gen_mem[idx];
            pay_rd_reg <= pay_mem[idx];
            seen_reg   <= written_reg[idx];
        end
    end

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign valid_vec = valid_reg;
    assign gen_q     = seen_reg ? gen_rd_reg : 8'd0;
    assign pay_q     = pay_rd_reg;

endmodule

>>> src/gtcs_victim.sv
// Eviction LFSR with a two-step reciprocal-multiply reduction modulo the slot count.
module gtcs_victim #(
    parameter int SLOTS = 8,
    parameter int IW    = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         seed_we,
    input  logic [gtcs_pkg::LFSR_W-1:0]  seed_data,
    input  logic                         start,
    output logic                         busy,
    output logic [IW-1:0]                victim_idx
);
    import gtcs_pkg::*;

    localparam int CW = $clog2(MOD_STEPS + 1);
    localparam int RW = 25;
    localparam int PW = LFSR_W + RW;
    localparam logic [RW-1:0] RECIP = RW'((1 << 24) / SLOTS);
    localparam logic [8:0] SLOTS_C = 9'(SLOTS);

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_adv;
    logic [LFSR_W-1:0] sh_reg;
    logic [PW-1:0]     prod;
    logic [LFSR_W-1:0] quo_reg;
    logic [LFSR_W+8:0] back;
    logic [9:0]        rem_tmp;
    logic [IW-1:0]     rem_reg;
    logic [IW-1:0]     rem_next;
    logic [CW-1:0]     cnt_reg;

    assign lfsr_adv = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                       lfsr_reg[LFSR_W-1:1]};

    // The estimated quotient is at most one below the true one.
    assign prod = {{RW{1'b0}}, sh_reg} * {{LFSR_W{1'b0}}, RECIP};
    assign back = {9'd0, quo_reg} * {{LFSR_W{1'b0}}, SLOTS_C};

    always_comb
    begin
        rem_tmp = sh_reg[9:0] - back[9:0];
        if (rem_tmp >= {1'b0, SLOTS_C})
        begin
            rem_next = IW'(rem_tmp - {1'b0, SLOTS_C});
        end
        else
        begin
            rem_next = IW'(rem_tmp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_RESET;
            cnt_reg  <= '0;
        end
        else if (seed_we)
        begin
            lfsr_reg <= seed_data;
        end
        else if (start)
        begin
            lfsr_reg <= lfsr_adv;
            cnt_reg  <= CW'(MOD_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg <= lfsr_adv;
        end
        if (cnt_reg == CW'(MOD_STEPS))
        begin
            quo_reg <= prod[LFSR_W+23:24];
        end
        if (cnt_reg == CW'(1))
        begin
            rem_reg <= rem_next;
        end
    end

    assign busy       = cnt_reg != '0;
    assign victim_idx = rem_reg;

endmodule

>>> src/generation_tagged_callback_slots.sv
// Top level of the generation-tagged callback slot table.
//
//   channel  | signals                    | direction
//   cmd      | cmd_valid, cmd_stall, cmd  | command word in
//   res      | res_valid, res_stall, res  | result word out
//   seed     | seed_we, seed_data         | LFSR seed write
//
// A word passes through accept, memory read and write-back; a close-all skips the read.
// An allocate that must evict first waits in the reduction state while the LFSR
// value is reduced modulo the slot count.
// The result register lets the next word be accepted while a result is held.
// Reset clears all valid bits and loads the LFSR with its reset seed.
// A stalled result holds the write-back stage until the result register frees.
module generation_tagged_callback_slots #(
    parameter int SLOTS     = 8,
    parameter int PAYLOAD_W = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  gtcs_pkg::cmd_t               cmd,
    output logic                         res_valid,
    input  logic                         res_stall,
    output gtcs_pkg::res_t               res,
    input  logic                         seed_we,
    input  logic [gtcs_pkg::LFSR_W-1:0]  seed_data
);
    import gtcs_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [8:0] SLOTS_9 = 9'(SLOTS);

    state_t               state_reg;
    state_t               state_next;
    op_t                  op_reg;
    logic [IW-1:0]        idx_reg;
    logic [IW-1:0]        idx_next;
    logic                 evict_reg;
    logic                 oor_reg;
    logic [7:0]           hgen_reg;
    logic [PAYLOAD_W-1:0] npay_reg;
    logic [PAYLOAD_W+31:0] npay_wide;
    logic [PAYLOAD_W+31:0] opay_wide;
    res_t                 res_reg;
    res_t                 res_next;
    logic                 res_valid_reg;

    logic                 accept;
    logic                 fin;
    logic                 vic_start;
    logic                 vic_busy;
    logic [IW-1:0]        victim_idx;
    store_ctl_t           ctl;
    logic [SLOTS-1:0]     valid_vec;
    logic                 free_any;
    logic [IW-1:0]        free_idx;
    logic [7:0]           gen_q;
    logic [PAYLOAD_W-1:0] pay_q;
    logic [7:0]           gen_inc;
    logic                 bad;

    gtcs_slot_store #(
        .SLOTS     (SLOTS),
        .PAYLOAD_W (PAYLOAD_W),
        .IW        (IW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .idx       (idx_reg),
        .wr_gen    (gen_inc),
        .wr_pay    (npay_reg),
        .valid_vec (valid_vec),
        .free_any  (free_any),
        .free_idx  (free_idx),
        .gen_q     (gen_q),
        .pay_q     (pay_q)
    );

    gtcs_victim #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_victim (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_data  (seed_data),
        .start      (vic_start),
        .busy       (vic_busy),
        .victim_idx (victim_idx)
    );

    assign accept  = (state_reg == S_IDLE) && cmd_valid;
    assign fin     = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);
    assign gen_inc = gen_q + 8'd1;
    assign bad     = oor_reg || !valid_vec[idx_reg] || (gen_q != hgen_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.opcode == OP_CLOSE)
                    begin
                        state_next = S_DONE;
                    end
                    else if ((cmd.opcode == OP_ALLOC) && !free_any)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_MOD:
            begin
                if (!vic_busy)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (fin)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_stall    = 1'b1;
        vic_start    = 1'b0;
        ctl          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                vic_start = cmd_valid && (cmd.opcode == OP_ALLOC) && !free_any;
            end
            S_MOD:
            begin
            end
            S_READ:
            begin
                ctl.rd = 1'b1;
            end
            S_DONE:
            begin
                ctl.wr_alloc = fin && (op_reg == OP_ALLOC);
                ctl.clr_all  = fin && (op_reg == OP_CLOSE);
                ctl.clr_one  = fin && ((op_reg == OP_FIRE) || (op_reg == OP_RELEASE)) && !bad;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (cmd.opcode == OP_ALLOC)
            begin
                idx_next = free_idx;
            end
            else
            begin
                idx_next = IW'(cmd.handle_slot);
            end
        end
        else if ((state_reg == S_MOD) && !vic_busy)
        begin
            idx_next = victim_idx;
        end
    end

    assign opay_wide = {{32{1'b0}}, pay_q};
    assign npay_wide = {{PAYLOAD_W{1'b0}}, cmd.new_payload};

    always_comb
    begin
        res_next = '0;
        unique case (op_reg)
            OP_ALLOC:
            begin
                res_next.out_slot = 8'(idx_reg);
                res_next.out_gen  = gen_inc;
                res_next.evicted  = evict_reg;
                if (evict_reg)
                begin
                    res_next.out_payload = opay_wide[31:0];
                end
            end
            OP_FIRE, OP_RELEASE:
            begin
                res_next.status = bad;
                if ((op_reg == OP_FIRE) && !bad)
                begin
                    res_next.out_payload = opay_wide[31:0];
                end
            end
            OP_CLOSE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            op_reg    <= cmd.opcode;
            evict_reg <= (cmd.opcode == OP_ALLOC) && !free_any;
            oor_reg   <= {1'b0, cmd.handle_slot} >= SLOTS_9;
            hgen_reg  <= cmd.handle_gen;
            npay_reg  <= npay_wide[PAYLOAD_W-1:0];
        end
        if (fin)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_fin_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> res_valid)
        else $error("finished command did not produce a result word");

    a_victim_only_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        vic_busy |-> (state_reg == S_MOD))
        else $error("victim unit busy outside the reduction state");

    a_alloc_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && (op_reg == OP_ALLOC)) |=> valid_vec[$past(idx_reg)])
        else $error("allocated slot not marked valid");
`endif

endmodule
